@@ src/csc_pkg.sv @@
// ----------------------------------------------------------------------------
// Calendar seconds converter package
// Shared state encoding, control and status structs, calendar constants and lengths.
// ----------------------------------------------------------------------------
package csc_pkg;

  localparam logic [31:0] SEC_PER_MIN     = 32'd60;
  localparam logic [31:0] SEC_PER_HOUR    = 32'd3600;
  localparam logic [31:0] SEC_PER_DAY     = 32'd86400;
  localparam logic [31:0] SEC_PER_LEAPYR  = 32'd31622400;
  localparam logic [31:0] SEC_PER_PLAINYR = 32'd31536000;
  localparam logic [11:0] EPOCH_YEAR_RST  = 12'd1970;
  localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENC_YEAR,
    ST_ENC_MONTH,
    ST_ENC_TIME1,
    ST_ENC_TIME2,
    ST_DEC_YEAR,
    ST_DEC_MONTH,
    ST_DEC_DAY,
    ST_DEC_HOUR,
    ST_DEC_MIN,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       out_load;
    ctl_state_t phase;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic mode;
  } dp_status_t;

  // Length of a year in seconds; a year is leap when its low two bits are zero.
  function automatic logic [31:0] year_secs(input logic [12:0] y);
    year_secs = (y[1:0] == 2'b00) ? SEC_PER_LEAPYR : SEC_PER_PLAINYR;
  endfunction

  // Length of a month in seconds; months outside 1 to 12 are empty.
  function automatic logic [31:0] month_secs(input logic [12:0] y, input logic [3:0] m);
    logic [31:0] s;
    begin
      unique case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: s = 32'd2678400;
        4'd4, 4'd6, 4'd9, 4'd11:                   s = 32'd2592000;
        4'd2: s = (y[1:0] == 2'b00) ? 32'd2505600 : 32'd2419200;
        default: s = 32'd0;
      endcase
      month_secs = s;
    end
  endfunction

endpackage

@@ src/calendar_seconds_converter_unit.sv @@
// ----------------------------------------------------------------------------
// Calendar seconds converter
// Converts between a calendar date-time and seconds since a base year.
// ----------------------------------------------------------------------------
// One word is worked on at a time. A date-time to seconds word (mode 0) walks
// the year offset (0 to 255), then the months before the given one, adding one
// year or month length per cycle to the 32-bit accumulator, then adds the day
// and hour terms and then the minute and second terms. A seconds to date-time
// word (mode 1) walks the accumulator down over years (up to 136), months (up
// to 11), days (up to 30), hours (up to 23) and minutes (up to 59). A new word
// is taken as soon as the previous one has reached the result register, even
// while that result is still stalled. A year is leap when its low two bits are
// zero; the epoch year may be written only while the unit is idle.
// ----------------------------------------------------------------------------
module calendar_seconds_converter_unit
  import csc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [31:0] in_seconds,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_seconds,
  output logic [12:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second
);

  dp_cmd_t    cmd;
  dp_status_t status;

  csc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  csc_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_mode     (in_mode),
    .in_seconds  (in_seconds),
    .in_year     (in_year),
    .in_month    (in_month),
    .in_day      (in_day),
    .in_hour     (in_hour),
    .in_minute   (in_minute),
    .in_second   (in_second),
    .cmd         (cmd),
    .status      (status),
    .out_seconds (out_seconds),
    .out_year    (out_year),
    .out_month   (out_month),
    .out_day     (out_day),
    .out_hour    (out_hour),
    .out_minute  (out_minute),
    .out_second  (out_second)
  );

  // An accepted word keeps the input side busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting a word");

  // A new result only appears at the end of a conversion.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result presented without a conversion in progress");

  // A decoded date-time always lies in range.
  a_decode_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_month != 4'd0) |->
      (out_month <= MONTHS_PER_YEAR && out_day != 5'd0 && out_hour < 5'd24 &&
       out_minute < 6'd60 && out_second < 6'd60))
    else $error("decoded date-time out of range");

endmodule

@@ src/csc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Calendar seconds converter controller
// Sequences the conversion phases and owns the handshake state of both words.
// ----------------------------------------------------------------------------
module csc_ctrl
  import csc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (accept) state_nxt = status.mode ? ST_DEC_YEAR : ST_ENC_YEAR;
      ST_ENC_YEAR:  if (status.done) state_nxt = ST_ENC_MONTH;
      ST_ENC_MONTH: if (status.done) state_nxt = ST_ENC_TIME1;
      ST_ENC_TIME1: state_nxt = ST_ENC_TIME2;
      ST_ENC_TIME2: state_nxt = ST_FINISH;
      ST_DEC_YEAR:  if (status.done) state_nxt = ST_DEC_MONTH;
      ST_DEC_MONTH: if (status.done) state_nxt = ST_DEC_DAY;
      ST_DEC_DAY:   if (status.done) state_nxt = ST_DEC_HOUR;
      ST_DEC_HOUR:  if (status.done) state_nxt = ST_DEC_MIN;
      ST_DEC_MIN:   if (status.done) state_nxt = ST_FINISH;
      ST_FINISH:    if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd.load     = accept;
    cmd.phase    = state_r;
    cmd.out_load = (state_r == ST_FINISH) && out_free;
    unique case (state_r)
      ST_ENC_TIME1, ST_ENC_TIME2: cmd.step = 1'b1;
      ST_ENC_YEAR, ST_ENC_MONTH, ST_DEC_YEAR, ST_DEC_MONTH,
      ST_DEC_DAY, ST_DEC_HOUR, ST_DEC_MIN: cmd.step = !status.done;
      default: cmd.step = 1'b0;
    endcase
    out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ src/csc_datapath.sv @@
// ----------------------------------------------------------------------------
// Calendar seconds converter datapath
// Accumulator, year and month walkers, time counters and the result register.
// ----------------------------------------------------------------------------
module csc_datapath
  import csc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        in_mode,
  input  logic [31:0] in_seconds,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic [31:0] out_seconds,
  output logic [12:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second
);

  logic [11:0] epoch_year_r;
  logic        mode_r;
  logic [11:0] year_in_r;
  logic [3:0]  month_in_r;
  logic [4:0]  day_in_r;
  logic [4:0]  hour_in_r;
  logic [5:0]  min_in_r;
  logic [5:0]  sec_in_r;
  logic [7:0]  offs_r;

  logic [31:0] acc_r, acc_nxt;
  logic [12:0] cur_year_r, cur_year_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [4:0]  day_cnt_r, day_cnt_nxt;
  logic [4:0]  hour_cnt_r, hour_cnt_nxt;
  logic [5:0]  min_cnt_r, min_cnt_nxt;
  logic        done;

  logic [31:0] out_seconds_r;
  logic [12:0] out_year_r;
  logic [3:0]  out_month_r;
  logic [4:0]  out_day_r;
  logic [4:0]  out_hour_r;
  logic [5:0]  out_minute_r;
  logic [5:0]  out_second_r;

  logic [31:0] ylen;
  logic [31:0] mlen;
  logic [31:0] day_term;
  logic [31:0] hour_term;
  logic [31:0] min_term;
  logic [12:0] enc_year;
  logic [11:0] offs_w;

  assign ylen      = year_secs(cur_year_r);
  assign enc_year  = {1'b0, year_in_r};
  assign mlen      = month_secs(mode_r ? cur_year_r : enc_year, mon_r);
  // Day zero wraps to minus one day.
  assign day_term  = (32'(day_in_r) - 32'd1) * SEC_PER_DAY;
  assign hour_term = 32'(hour_in_r) * SEC_PER_HOUR;
  assign min_term  = 32'(min_in_r) * SEC_PER_MIN;
  assign offs_w    = in_year - epoch_year_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_year_r <= EPOCH_YEAR_RST;
    end else if (cfg_we) begin
      epoch_year_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r     <= in_mode;
      year_in_r  <= in_year;
      month_in_r <= in_month;
      day_in_r   <= in_day;
      hour_in_r  <= in_hour;
      min_in_r   <= in_minute;
      sec_in_r   <= in_second;
      offs_r     <= offs_w[7:0];
    end
  end

  always_comb begin
    done = 1'b1;
    unique case (cmd.phase)
      ST_ENC_YEAR:  done = (idx_r == offs_r);
      ST_ENC_MONTH: done = (mon_r >= month_in_r);
      ST_DEC_YEAR:  done = (acc_r < ylen);
      ST_DEC_MONTH: done = (mon_r > MONTHS_PER_YEAR) || (acc_r < mlen);
      ST_DEC_DAY:   done = (acc_r < SEC_PER_DAY);
      ST_DEC_HOUR:  done = (acc_r < SEC_PER_HOUR);
      ST_DEC_MIN:   done = (acc_r < SEC_PER_MIN);
      default:      done = 1'b1;
    endcase
  end

  always_comb begin
    acc_nxt      = acc_r;
    cur_year_nxt = cur_year_r;
    idx_nxt      = idx_r;
    mon_nxt      = mon_r;
    day_cnt_nxt  = day_cnt_r;
    hour_cnt_nxt = hour_cnt_r;
    min_cnt_nxt  = min_cnt_r;
    if (cmd.load) begin
      acc_nxt      = in_mode ? in_seconds : 32'd0;
      cur_year_nxt = {1'b0, epoch_year_r};
      idx_nxt      = 8'd0;
      mon_nxt      = 4'd1;
      day_cnt_nxt  = 5'd1;
      hour_cnt_nxt = 5'd0;
      min_cnt_nxt  = 6'd0;
    end else if (cmd.step) begin
      unique case (cmd.phase)
        ST_ENC_YEAR: begin
          acc_nxt      = acc_r + ylen;
          cur_year_nxt = cur_year_r + 13'd1;
          idx_nxt      = idx_r + 8'd1;
        end
        ST_ENC_MONTH: begin
          acc_nxt = acc_r + mlen;
          mon_nxt = mon_r + 4'd1;
        end
        ST_ENC_TIME1: acc_nxt = acc_r + day_term + hour_term;
        ST_ENC_TIME2: acc_nxt = acc_r + min_term + 32'(sec_in_r);
        ST_DEC_YEAR: begin
          acc_nxt      = acc_r - ylen;
          cur_year_nxt = cur_year_r + 13'd1;
        end
        ST_DEC_MONTH: begin
          acc_nxt = acc_r - mlen;
          mon_nxt = mon_r + 4'd1;
        end
        ST_DEC_DAY: begin
          acc_nxt     = acc_r - SEC_PER_DAY;
          day_cnt_nxt = day_cnt_r + 5'd1;
        end
        ST_DEC_HOUR: begin
          acc_nxt      = acc_r - SEC_PER_HOUR;
          hour_cnt_nxt = hour_cnt_r + 5'd1;
        end
        ST_DEC_MIN: begin
          acc_nxt     = acc_r - SEC_PER_MIN;
          min_cnt_nxt = min_cnt_r + 6'd1;
        end
        default: acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    cur_year_r <= cur_year_nxt;
    idx_r      <= idx_nxt;
    mon_r      <= mon_nxt;
    day_cnt_r  <= day_cnt_nxt;
    hour_cnt_r <= hour_cnt_nxt;
    min_cnt_r  <= min_cnt_nxt;
  end

  // Result register; fields that the mode does not use read as zero.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (mode_r) begin
        out_seconds_r <= 32'd0;
        out_year_r    <= cur_year_r;
        out_month_r   <= mon_r;
        out_day_r     <= day_cnt_r;
        out_hour_r    <= hour_cnt_r;
        out_minute_r  <= min_cnt_r;
        out_second_r  <= acc_r[5:0];
      end else begin
        out_seconds_r <= acc_r;
        out_year_r    <= 13'd0;
        out_month_r   <= 4'd0;
        out_day_r     <= 5'd0;
        out_hour_r    <= 5'd0;
        out_minute_r  <= 6'd0;
        out_second_r  <= 6'd0;
      end
    end
  end

  assign status.done = done;
  assign status.mode = cmd.load ? in_mode : mode_r;

  assign out_seconds = out_seconds_r;
  assign out_year    = out_year_r;
  assign out_month   = out_month_r;
  assign out_day     = out_day_r;
  assign out_hour    = out_hour_r;
  assign out_minute  = out_minute_r;
  assign out_second  = out_second_r;

endmodule

@@ tb/sv/calendar_word_checker.sv @@
// ----------------------------------------------------------------------------
// Calendar word checker
// Watches both channels of the converter, predicts each result word from the
// accepted input word and the current base year, and compares in order.
// ----------------------------------------------------------------------------
module calendar_word_checker
  import csc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_mode,
  input  logic [31:0] in_seconds,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_seconds,
  input  logic [12:0] out_year,
  input  logic [3:0]  out_month,
  input  logic [4:0]  out_day,
  input  logic [4:0]  out_hour,
  input  logic [5:0]  out_minute,
  input  logic [5:0]  out_second,
  output int          fail_count,
  output int          pending_words
);

  typedef struct packed {
    logic [31:0] seconds;
    logic [12:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_word_t;

  calendar_word_t expected_words[$];
  logic [11:0]    epoch_year_q;
  int             errors = 0;

  function automatic bit is_leap_yr(input int unsigned y);
    return y[1:0] == 2'b00;
  endfunction

  function automatic int unsigned year_length(input int unsigned y);
    return is_leap_yr(y) ? SEC_PER_LEAPYR : SEC_PER_PLAINYR;
  endfunction

  // Months outside 1 to 12 have no length at all.
  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    int unsigned days;
    case (m)
      1, 3, 5, 7, 8, 10, 12: days = 31;
      4, 6, 9, 11:           days = 30;
      2:                     days = is_leap_yr(y) ? 29 : 28;
      default:               days = 0;
    endcase
    return days * SEC_PER_DAY;
  endfunction

  // Everything wraps at 32 bits; day zero steps one day back.
  function automatic calendar_word_t date_to_seconds(
    input logic [11:0] base, input logic [11:0] year, input logic [3:0] month,
    input logic [4:0] day, input logic [4:0] hour, input logic [5:0] minute,
    input logic [5:0] second);
    calendar_word_t w;
    int unsigned    offs, acc, i, d;
    w    = '0;
    offs = (32'(year) - 32'(base)) & 32'hFF;
    acc  = 0;
    for (i = 0; i < offs; i++)
      acc += year_length(32'(base) + i);
    for (i = 1; i < 32'(month); i++)
      acc += month_length(32'(year), i);
    d = 32'(day);
    acc += (d - 1) * SEC_PER_DAY;
    acc += 32'(hour) * SEC_PER_HOUR;
    acc += 32'(minute) * SEC_PER_MIN;
    acc += 32'(second);
    w.seconds = acc;
    return w;
  endfunction

  function automatic calendar_word_t seconds_to_date(
    input logic [11:0] base, input logic [31:0] secs);
    calendar_word_t w;
    int unsigned    rest, y, m;
    w    = '0;
    rest = secs;
    y    = 32'(base);
    m    = 1;
    while (rest >= year_length(y)) begin
      rest -= year_length(y);
      y++;
    end
    while (m <= 12 && rest >= month_length(y, m)) begin
      rest -= month_length(y, m);
      m++;
    end
    w.year   = y[12:0];
    w.month  = m[3:0];
    w.day    = 5'(rest / SEC_PER_DAY + 1);
    rest     = rest % SEC_PER_DAY;
    w.hour   = 5'(rest / SEC_PER_HOUR);
    rest     = rest % SEC_PER_HOUR;
    w.minute = 6'(rest / SEC_PER_MIN);
    w.second = 6'(rest % SEC_PER_MIN);
    return w;
  endfunction

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= 10)
      $display("%s", msg);
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got)
      note_failure($sformatf("mismatch on %s: expected %0d, got %0d", what, want, got));
  endtask

  always @(posedge clk) begin : watch
    calendar_word_t want;
    if (!rst_n) begin
      epoch_year_q <= EPOCH_YEAR_RST;
      expected_words.delete();
    end else begin
      if (cfg_we)
        epoch_year_q <= cfg_wdata;
      // Results are retired before new predictions are queued, so a word that
      // shows up with nothing outstanding is never masked.
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          note_failure($sformatf("result word with nothing outstanding: seconds %0d year %0d",
                                 out_seconds, out_year));
        end else begin
          want = expected_words.pop_front();
          compare_field("seconds", want.seconds, out_seconds);
          compare_field("year", 32'(want.year), 32'(out_year));
          compare_field("month", 32'(want.month), 32'(out_month));
          compare_field("day", 32'(want.day), 32'(out_day));
          compare_field("hour", 32'(want.hour), 32'(out_hour));
          compare_field("minute", 32'(want.minute), 32'(out_minute));
          compare_field("second", 32'(want.second), 32'(out_second));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_mode)
          expected_words.push_back(seconds_to_date(epoch_year_q, in_seconds));
        else
          expected_words.push_back(date_to_seconds(epoch_year_q, in_year, in_month, in_day,
                                                   in_hour, in_minute, in_second));
      end
    end
    pending_words <= expected_words.size();
    fail_count    <= errors;
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Calendar seconds converter testbench
// Drives directed corner words and then random words under several base
// years, with random idle and stall bursts; a checker compares every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int WORDS_PER_PHASE = 150;
  localparam int PHASES          = 6;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [11:0] cfg_wdata  = '0;
  logic        in_valid   = 1'b0;
  logic        in_mode    = 1'b0;
  logic [31:0] in_seconds = '0;
  logic [11:0] in_year    = '0;
  logic [3:0]  in_month   = '0;
  logic [4:0]  in_day     = '0;
  logic [4:0]  in_hour    = '0;
  logic [5:0]  in_minute  = '0;
  logic [5:0]  in_second  = '0;
  logic        out_stall  = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [31:0] out_seconds;
  logic [12:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;

  logic        calm        = 1'b0;
  int          stall_left  = 0;
  int          cycle_count = 0;
  int          fail_count;
  int          pending_words;
  logic [11:0] phase_base [PHASES];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  calendar_seconds_converter_unit uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_seconds(in_seconds), .in_year(in_year), .in_month(in_month),
    .in_day(in_day), .in_hour(in_hour), .in_minute(in_minute), .in_second(in_second),
    .out_valid(out_valid), .out_stall(out_stall), .out_seconds(out_seconds),
    .out_year(out_year), .out_month(out_month), .out_day(out_day),
    .out_hour(out_hour), .out_minute(out_minute), .out_second(out_second)
  );

  calendar_word_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_seconds(in_seconds), .in_year(in_year), .in_month(in_month),
    .in_day(in_day), .in_hour(in_hour), .in_minute(in_minute), .in_second(in_second),
    .out_valid(out_valid), .out_stall(out_stall), .out_seconds(out_seconds),
    .out_year(out_year), .out_month(out_month), .out_day(out_day),
    .out_hour(out_hour), .out_minute(out_minute), .out_second(out_second),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result stalls come in bursts whose length is drawn at random when a burst begins.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_word(input logic mode, input logic [31:0] secs,
                           input logic [11:0] year, input logic [3:0] month,
                           input logic [4:0] day, input logic [4:0] hour,
                           input logic [5:0] minute, input logic [5:0] second);
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_seconds <= secs;
    in_year    <= year;
    in_month   <= month;
    in_day     <= day;
    in_hour    <= hour;
    in_minute  <= minute;
    in_second  <= second;
    do @(posedge clk); while (in_stall);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Mostly years just past the base so the year walk stays short; a few sit
  // just below it, which wraps to the longest walks or close to them.
  task automatic send_random_word(input logic [11:0] base);
    logic [31:0] secs;
    logic [11:0] year;
    int          pick;
    secs = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 4)
      secs = $urandom_range(0, 200_000_000);
    else if (pick == 4)
      secs = 32'hFFFF_FFFF - $urandom_range(0, 100_000);
    pick = $urandom_range(0, 9);
    if (pick < 7)
      year = 12'(32'(base) + $urandom_range(0, 6));
    else if (pick < 9)
      year = 12'(32'(base) - $urandom_range(1, 4));
    else
      year = 12'($urandom_range(0, 4095));
    send_word(1'($urandom_range(0, 1)), secs, year,
              4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12)),
              5'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 31)),
              5'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23)),
              6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59)),
              6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59)));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_base(input logic [11:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase;
    phase_base[0] = 12'd1970;
    phase_base[1] = 12'd0;
    phase_base[2] = 12'd4095;
    phase_base[3] = 12'd2000;
    phase_base[4] = 12'($urandom_range(0, 4095));
    phase_base[5] = 12'($urandom_range(0, 4095));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words run under the base year left by reset.
    send_word(1'b0, $urandom, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_word(1'b0, $urandom, 12'd1970, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    send_word(1'b0, '1, 12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
    send_word(1'b0, $urandom, 12'd1969, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_word(1'b0, $urandom, 12'd2225, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    send_word(1'b0, $urandom, 12'd1972, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_word(1'b0, $urandom, 12'd1973, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_word(1'b0, $urandom, 12'd1971, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0);
    send_word(1'b0, $urandom, 12'd1971, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0);
    send_word(1'b0, $urandom, 12'd1971, 4'd2, 5'd0, 5'd0, 6'd0, 6'd0);
    send_word(1'b0, $urandom, 12'd1970, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0);
    send_word(1'b0, '0, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_word(1'b1, 32'd0, '1, '1, '1, '1, '1, '1);
    send_word(1'b1, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0);
    send_word(1'b1, 32'd31535999, 12'($urandom), 4'($urandom), 5'($urandom),
              5'($urandom), 6'($urandom), 6'($urandom));
    send_word(1'b1, 32'd31536000, 12'($urandom), 4'($urandom), 5'($urandom),
              5'($urandom), 6'($urandom), 6'($urandom));
    send_word(1'b1, 32'd68169600, 12'($urandom), 4'($urandom), 5'($urandom),
              5'($urandom), 6'($urandom), 6'($urandom));
    send_word(1'b1, 32'd68255999, 12'($urandom), 4'($urandom), 5'($urandom),
              5'($urandom), 6'($urandom), 6'($urandom));
    send_word(1'b1, 32'd86399, 12'($urandom), 4'($urandom), 5'($urandom),
              5'($urandom), 6'($urandom), 6'($urandom));
    send_word(1'b1, 32'd86400, 12'($urandom), 4'($urandom), 5'($urandom),
              5'($urandom), 6'($urandom), 6'($urandom));
    wait_idle();

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES - 1)
        calm <= 1'b1;
      write_base(phase_base[phase]);
      repeat (WORDS_PER_PHASE) send_random_word(phase_base[phase]);
      wait_idle();
    end

    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending_words == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
src/csc_pkg.sv
src/csc_ctrl.sv
src/csc_datapath.sv
src/calendar_seconds_converter_unit.sv
tb/sv/calendar_word_checker.sv
tb/sv/tb.sv
